/* design/relative_order_sorter_macros.svh */
// ---------------------------------------------------------------------------
// relative_order_sorter_macros.svh
// Assertion macros for the relative order sorter modules (used in ros_seq).
// They expect signals named clk and rst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef RELATIVE_ORDER_SORTER_MACROS_SVH
`define RELATIVE_ORDER_SORTER_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define ROS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ROS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ROS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ros_pkg.sv */
// ---------------------------------------------------------------------------
// ros_pkg
// Constants, codes and types shared by the relative order sorter modules.
// ---------------------------------------------------------------------------
package ros_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 10;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_ORDER  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  ovf;
  } ros_emit_t;

endpackage

/* design/relative_order_sorter.sv */
// ---------------------------------------------------------------------------
// relative_order_sorter
// Relative sort of a data list by an order list.
// ---------------------------------------------------------------------------
// Input beats carry an opcode and a value. Opcode 0 appends the value to the
// order list and opcode 1 to the data list while the block is idle, and
// loads beyond DEPTH entries are dropped and flag the next run as overflowed.
// Opcode 2 starts a run: first every unused data element matching each order
// entry is emitted in data-list order, then the remaining elements ascending.
// Opcode 3 is ignored. One result beat per data element; the final one
// carries out_last, and the run then clears both lists.
// A run reads both list stores through one read port each. The match phase
// scans the data list once per order entry, reading and comparing each
// element in turn; each pass of the ascending phase scans it once more for
// the smallest unused element and then emits that element.
// in_ready is low for the whole run. Results pass through an output register,
// so a stalled receiver only holds the sequencer when a new beat is ready.
// Reset empties both lists and the overflow flag and drops any pending beat;
// the store contents themselves are not cleared, as only filled entries are
// ever read.
// ---------------------------------------------------------------------------
module relative_order_sorter
  import ros_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_sorted_value,
  output logic                  out_last,
  output logic                  out_overflowed
);

  logic                  ord_we;
  logic [AW-1:0]         ord_waddr;
  logic [AW-1:0]         ord_raddr;
  logic [VALUE_BITS-1:0] ord_rdata;
  logic                  dat_we;
  logic [AW-1:0]         dat_waddr;
  logic [AW-1:0]         dat_raddr;
  logic [VALUE_BITS-1:0] dat_rdata;
  logic                  out_free;
  ros_emit_t             emit;

  // Order list store.
  ros_ram u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (in_value),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Data list store.
  ros_ram u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (in_value),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  // Sequencer with the shared compare unit and the used flags.
  ros_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .ord_we    (ord_we),
    .ord_waddr (ord_waddr),
    .ord_raddr (ord_raddr),
    .ord_rdata (ord_rdata),
    .dat_we    (dat_we),
    .dat_waddr (dat_waddr),
    .dat_raddr (dat_raddr),
    .dat_rdata (dat_rdata),
    .out_free  (out_free),
    .emit      (emit)
  );

  // Result beats wait here while the receiver stalls.
  ros_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .emit             (emit),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last         (out_last),
    .out_overflowed   (out_overflowed)
  );

endmodule

/* design/ros_ram.sv */
// ---------------------------------------------------------------------------
// ros_ram
// List store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ros_ram
  import ros_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/ros_out_reg.sv */
// ---------------------------------------------------------------------------
// ros_out_reg
// Output register for result beats, holding a beat while the receiver stalls.
// ---------------------------------------------------------------------------
module ros_out_reg
  import ros_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ros_emit_t             emit,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_sorted_value,
  output logic                  out_last,
  output logic                  out_overflowed
);

  logic                  valid_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  last_r;
  logic                  ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      value_r <= emit.value;
      last_r  <= emit.last;
      ovf_r   <= emit.ovf;
    end
  end

  // A new beat may be loaded when the register is empty or is being drained.
  assign free             = !valid_r || out_ready;
  assign out_valid        = valid_r;
  assign out_sorted_value = value_r;
  assign out_last         = last_r;
  assign out_overflowed   = ovf_r;

endmodule

/* design/ros_seq.sv */
// ---------------------------------------------------------------------------
// ros_seq
// Sequencer: list counts, used flags and the shared compare unit.
// ---------------------------------------------------------------------------
`include "relative_order_sorter_macros.svh"

module ros_seq
  import ros_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  output logic                  ord_we,
  output logic [AW-1:0]         ord_waddr,
  output logic [AW-1:0]         ord_raddr,
  input  logic [VALUE_BITS-1:0] ord_rdata,
  output logic                  dat_we,
  output logic [AW-1:0]         dat_waddr,
  output logic [AW-1:0]         dat_raddr,
  input  logic [VALUE_BITS-1:0] dat_rdata,
  input  logic                  out_free,
  output ros_emit_t             emit
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ORD   = 7'b0000010,
    ST_MRD   = 7'b0000100,
    ST_MCMP  = 7'b0001000,
    ST_SRD   = 7'b0010000,
    ST_SCMP  = 7'b0100000,
    ST_SEMIT = 7'b1000000
  } ros_state_t;

  ros_state_t            state_r,     state_nxt;
  logic [CW-1:0]         data_cnt_r,  data_cnt_nxt;
  logic [CW-1:0]         order_cnt_r, order_cnt_nxt;
  logic [CW-1:0]         em_cnt_r,    em_cnt_nxt;
  logic [DEPTH-1:0]      used_r,      used_nxt;
  logic                  ovf_r,       ovf_nxt;
  logic [AW-1:0]         i_r,         i_nxt;
  logic [AW-1:0]         j_r,         j_nxt;
  logic                  found_r,     found_nxt;
  logic [VALUE_BITS-1:0] best_r,      best_nxt;
  logic [AW-1:0]         best_idx_r,  best_idx_nxt;

  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;
  logic          is_last;
  logic          match;
  logic          take;
  logic          do_clear;

  assign i_inc   = CW'(i_r) + CW'(1);
  assign j_inc   = CW'(j_r) + CW'(1);
  assign is_last = (em_cnt_r + CW'(1)) == data_cnt_r;
  assign match   = !used_r[j_r] && (dat_rdata == ord_rdata);
  assign take    = !used_r[j_r] && (!found_r || (dat_rdata < best_r));

  assign in_ready  = (state_r == ST_IDLE);
  assign ord_waddr = order_cnt_r[AW-1:0];
  assign dat_waddr = data_cnt_r[AW-1:0];
  assign ord_raddr = i_r;
  assign dat_raddr = j_r;

  always_comb begin
    state_nxt     = state_r;
    data_cnt_nxt  = data_cnt_r;
    order_cnt_nxt = order_cnt_r;
    em_cnt_nxt    = em_cnt_r;
    used_nxt      = used_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    ord_we        = 1'b0;
    dat_we        = 1'b0;
    do_clear      = 1'b0;
    emit          = '0;
    emit.value    = dat_rdata;
    emit.last     = is_last;
    emit.ovf      = ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_ORDER: begin
              if (order_cnt_r < CW'(DEPTH)) begin
                ord_we        = 1'b1;
                order_cnt_nxt = order_cnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_DATA: begin
              if (data_cnt_r < CW'(DEPTH)) begin
                dat_we                          = 1'b1;
                used_nxt[data_cnt_r[AW-1:0]]    = 1'b0;
                data_cnt_nxt                    = data_cnt_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_FINISH: begin
              i_nxt      = '0;
              j_nxt      = '0;
              found_nxt  = 1'b0;
              em_cnt_nxt = '0;
              if (data_cnt_r == '0) begin
                do_clear = 1'b1;
              end else if (order_cnt_r == '0) begin
                state_nxt = ST_SRD;
              end else begin
                state_nxt = ST_ORD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ORD: begin
        j_nxt     = '0;
        state_nxt = ST_MRD;
      end
      ST_MRD: begin
        state_nxt = ST_MCMP;
      end
      ST_MCMP: begin
        if (!(match && !out_free)) begin
          if (match) begin
            emit.valid    = 1'b1;
            used_nxt[j_r] = 1'b1;
            em_cnt_nxt    = em_cnt_r + CW'(1);
          end
          if (match && is_last) begin
            do_clear = 1'b1;
          end else if (j_inc < data_cnt_r) begin
            j_nxt     = j_r + AW'(1);
            state_nxt = ST_MRD;
          end else if (i_inc < order_cnt_r) begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_ORD;
          end else begin
            j_nxt     = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        if (take) begin
          found_nxt    = 1'b1;
          best_nxt     = dat_rdata;
          best_idx_nxt = j_r;
        end
        if (j_inc < data_cnt_r) begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_SRD;
        end else begin
          state_nxt = ST_SEMIT;
        end
      end
      ST_SEMIT: begin
        if (!found_r) begin
          do_clear = 1'b1;
        end else if (out_free) begin
          emit.valid           = 1'b1;
          emit.value           = best_r;
          used_nxt[best_idx_r] = 1'b1;
          em_cnt_nxt           = em_cnt_r + CW'(1);
          j_nxt                = '0;
          found_nxt            = 1'b0;
          if (is_last) begin
            do_clear = 1'b1;
          end else begin
            state_nxt = ST_SRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_clear) begin
      used_nxt      = '0;
      data_cnt_nxt  = '0;
      order_cnt_nxt = '0;
      em_cnt_nxt    = '0;
      ovf_nxt       = 1'b0;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      data_cnt_r  <= '0;
      order_cnt_r <= '0;
      em_cnt_r    <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      data_cnt_r  <= data_cnt_nxt;
      order_cnt_r <= order_cnt_nxt;
      em_cnt_r    <= em_cnt_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  `ROS_ASSERT_IMP(a_emit_room, emit.valid, out_free, "result beat into a full register")
  `ROS_ASSERT_ALWAYS(a_cnt_range, (data_cnt_r <= CW'(DEPTH)) && (order_cnt_r <= CW'(DEPTH)), "count")
  `ROS_ASSERT_NXT(a_last_clears, emit.valid && emit.last, data_cnt_r == '0, "run not ended")
  `ROS_ASSERT_IMP(a_busy_has_data, state_r != ST_IDLE, data_cnt_r != '0, "run with no data")

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for relative_order_sorter: loads order and data lists,
// finishes runs under random and forced back-pressure, and compares every
// result beat with a behavioural prediction of the relative sort.
// ---------------------------------------------------------------------------
module tb;
  import ros_pkg::*;

  // The package names only the three live opcodes; the fourth is ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The cap allows for runs with full lists, for every random stall and for the hold-off.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // Time for any stray beat to show up after the last run has drained.
  localparam int SETTLE_CYCLES = 4 * DEPTH;
  localparam int MAX_PRINTS    = 100;

  typedef logic [VALUE_BITS-1:0] value_t;

  // One expected result beat.
  typedef struct packed {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_beat_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = OP_ORDER;
  value_t     in_value  = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  value_t     out_sorted_value;
  logic       out_last;
  logic       out_overflowed;

  // Behavioural copy of the block's lists and of the dropped-load flag.
  value_t       order_list[$];
  value_t       data_list[$];
  logic         dropped_load = 1'b0;
  // Result beats predicted but not yet seen on the output.
  sorted_beat_t sorted_q[$];

  int err_count   = 0;
  int cycle_count = 0;
  // Cycles left in a forced receiver hold-off.
  int hold_cycles = 0;
  // While calm is set neither side idles.
  bit calm        = 1'b0;

  relative_order_sorter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last         (out_last),
    .out_overflowed   (out_overflowed)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung block or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s, got %0d, wanted %0d", cycle_count, what, got,
               want);
    err_count++;
  endtask

  // Applies one accepted input beat to the behavioural state. Loads append
  // to a list unless it is full, in which case the load is lost and the
  // next run is flagged. A finish works out the whole run: matches for each
  // order entry in turn, taken in data-list order, then the leftovers in
  // ascending order, with the earlier data entry winning among equal values.
  function automatic void absorb_beat(input logic [1:0] op, input value_t val);
    sorted_beat_t run_q[$];
    sorted_beat_t beat;
    bit           taken[DEPTH];
    int           best;
    case (op)
      OP_ORDER: begin
        if (order_list.size() < DEPTH) order_list.insert(order_list.size(), val);
        else dropped_load = 1'b1;
      end
      OP_DATA: begin
        if (data_list.size() < DEPTH) data_list.insert(data_list.size(), val);
        else dropped_load = 1'b1;
      end
      OP_FINISH: begin
        beat.last = 1'b0;
        beat.ovf  = dropped_load;
        foreach (order_list[i]) begin
          foreach (data_list[j]) begin
            if (!taken[j] && data_list[j] == order_list[i]) begin
              taken[j]   = 1'b1;
              beat.value = data_list[j];
              run_q.insert(run_q.size(), beat);
            end
          end
        end
        do begin
          best = -1;
          foreach (data_list[j]) begin
            if (!taken[j] && (best < 0 || data_list[j] < data_list[best])) best = j;
          end
          if (best >= 0) begin
            taken[best] = 1'b1;
            beat.value  = data_list[best];
            run_q.insert(run_q.size(), beat);
          end
        end while (best >= 0);
        if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[k]) sorted_q.insert(sorted_q.size(), run_q[k]);
        order_list.delete();
        data_list.delete();
        dropped_load = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Offers one beat and holds it until the block takes it. Valid is left
  // high afterwards, so that back-to-back beats need no gap; a random gap,
  // when one is drawn, lowers valid first.
  task automatic send_beat(input logic [1:0] op, input value_t val);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    absorb_beat(op, val);
  endtask

  // Lowers valid and lets the edge pass, so that no later drive shares the
  // time step.
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic value_t any_value();
    return value_t'($urandom_range(0, (1 << VALUE_BITS) - 1));
  endfunction

  // Receiver: honours a forced hold-off first, otherwise stalls now and then.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Result checker: every beat taken is compared with the oldest prediction.
  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", out_sorted_value, 0);
      end else begin
        want = sorted_q.pop_front();
        if (out_sorted_value !== want.value)
          report_mismatch("sorted_value", out_sorted_value, want.value);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
        if (out_overflowed !== want.ovf)
          report_mismatch("overflowed", out_overflowed, want.ovf);
      end
    end
  end

  // Extreme values on both lists, bit patterns that toggle every value bit,
  // and duplicate data elements that must all come out.
  task automatic test_extremes();
    send_beat(OP_ORDER, '1);
    send_beat(OP_ORDER, '0);
    send_beat(OP_DATA, '0);
    send_beat(OP_DATA, '1);
    send_beat(OP_DATA, 10'h2AA);
    send_beat(OP_DATA, '0);
    send_beat(OP_DATA, 10'h155);
    send_beat(OP_DATA, '1);
    send_beat(OP_FINISH, 10'h3FF);
    idle_input();
    wait_drain();
  endtask

  // A finish with an empty data list emits nothing but still clears the
  // order list; a finish with both lists empty does the same.
  task automatic test_empty_data();
    send_beat(OP_ORDER, 10'd7);
    send_beat(OP_ORDER, 10'd9);
    send_beat(OP_FINISH, '0);
    send_beat(OP_FINISH, '1);
    // The order list must now be empty, so 9 sorts as a leftover.
    send_beat(OP_DATA, 10'd9);
    send_beat(OP_DATA, 10'd7);
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
  endtask

  // A repeated order value finds its matches already used; equal leftovers
  // come out in data-list order.
  task automatic test_duplicate_orders();
    send_beat(OP_ORDER, 10'd5);
    send_beat(OP_ORDER, 10'd5);
    send_beat(OP_ORDER, 10'd7);
    send_beat(OP_DATA, 10'd7);
    send_beat(OP_DATA, 10'd5);
    send_beat(OP_DATA, 10'd3);
    send_beat(OP_DATA, 10'd5);
    send_beat(OP_DATA, 10'd3);
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
  endtask

  // The unused opcode must leave both lists untouched and emit nothing.
  task automatic test_unused_opcode();
    send_beat(OP_UNUSED, '1);
    send_beat(OP_DATA, 10'd12);
    send_beat(OP_UNUSED, 10'd11);
    send_beat(OP_ORDER, 10'd12);
    send_beat(OP_UNUSED, '0);
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
  endtask

  // Full data list: the load past DEPTH is dropped and flags every result of
  // a run with the most data elements; the runs of the later tests check that the
  // flag has cleared. The whole stretch runs with no idling on either side.
  task automatic test_full_lists();
    value_t base;
    base = value_t'($urandom_range(0, (1 << VALUE_BITS) - 16));
    calm = 1'b1;
    send_beat(OP_ORDER, base + value_t'(3));
    send_beat(OP_ORDER, base + value_t'(9));
    repeat (DEPTH + 1) send_beat(OP_DATA, base + value_t'($urandom_range(0, 15)));
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
    calm = 1'b0;
  endtask

  // The receiver holds off for a long stretch just after a finish, so the
  // output register fills, the run stalls and in_ready stays low while the
  // sender keeps offering loads. Afterwards the sender waits for every
  // result before going on.
  task automatic test_backpressure();
    repeat (8) send_beat(OP_DATA, value_t'($urandom_range(0, 15)));
    repeat (2) send_beat(OP_ORDER, value_t'($urandom_range(0, 15)));
    send_beat(OP_FINISH, '0);
    hold_cycles = 400;
    repeat (8) send_beat($urandom_range(0, 1) ? OP_DATA : OP_ORDER,
                         value_t'($urandom_range(0, 15)));
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
  endtask

  // One well-formed run with random content: order and data loads
  // interleaved, values mostly from a narrow pool so that matches happen,
  // an occasional ignored beat, then a finish.
  task automatic send_random_run(inout int sent);
    int     n_ord;
    int     n_dat;
    value_t base;
    value_t val;
    bit     pick_order;
    n_ord = $urandom_range(0, 4);
    n_dat = $urandom_range(0, 6);
    base = value_t'($urandom_range(0, (1 << VALUE_BITS) - 4));
    while (n_ord + n_dat > 0) begin
      if ($urandom_range(19) == 0) begin
        send_beat(OP_UNUSED, any_value());
        sent++;
      end
      val        = ($urandom_range(99) < 60) ? base + value_t'($urandom_range(0, 3))
                                             : any_value();
      pick_order = (n_dat == 0) || (n_ord > 0 && $urandom_range(0, n_ord + n_dat - 1) < n_ord);
      if (pick_order) begin
        send_beat(OP_ORDER, val);
        n_ord--;
      end else begin
        send_beat(OP_DATA, val);
        n_dat--;
      end
      sent++;
    end
    send_beat(OP_FINISH, any_value());
    sent++;
  endtask

  // Mostly well-formed runs, with some raw noise and premature finishes.
  task automatic test_random_runs();
    int sent;
    sent = 0;
    while (sent < 15) begin
      if ($urandom_range(99) < 85) begin
        send_random_run(sent);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(2'($urandom_range(0, 3)), any_value());
          sent++;
        end
      end
      if ($urandom_range(5) == 0) begin
        idle_input();
        wait_drain();
      end
    end
    send_beat(OP_FINISH, '0);
    idle_input();
    wait_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_empty_data();
    test_duplicate_orders();
    test_unused_opcode();
    test_full_lists();
    test_backpressure();
    test_random_runs();
    // Catch any stray beat after the last run.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sorted_q.size() != 0)
      report_mismatch("results still outstanding at the end", sorted_q.size(), 0);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
